/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

/* rtl/core/jcf_pkg.sv */
// Package with phase codes, token kinds and the token type of the class file parser.
`timescale 1ns / 1ps
package jcf_pkg;
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0, PH_MAGIC = 5'd1, PH_MINOR = 5'd2, PH_MAJOR = 5'd3, PH_PCOUNT = 5'd4,
    PH_PTAG = 5'd5, PH_PBODY = 5'd6, PH_UTFLEN = 5'd7, PH_UTFBYTES = 5'd8,
    PH_CFLAGS = 5'd9, PH_THIS = 5'd10, PH_SUPER = 5'd11, PH_ICOUNT = 5'd12,
    PH_IFACE = 5'd13, PH_FCOUNT = 5'd14, PH_MFLAGS = 5'd15, PH_MNAME = 5'd16,
    PH_MDESC = 5'd17, PH_MACOUNT = 5'd18, PH_MCOUNT = 5'd19, PH_ANAME = 5'd20,
    PH_ALEN = 5'd21, PH_ABYTES = 5'd22, PH_CACOUNT = 5'd23, PH_DONE = 5'd24,
    PH_ERROR = 5'd25
  } phase_t;

  localparam logic [4:0] K_MAGIC = 5'd0;
  localparam logic [4:0] K_MINOR = 5'd1;
  localparam logic [4:0] K_MAJOR = 5'd2;
  localparam logic [4:0] K_PCOUNT = 5'd3;
  localparam logic [4:0] K_PTAG = 5'd4;
  localparam logic [4:0] K_PU16 = 5'd5;
  localparam logic [4:0] K_PU32 = 5'd6;
  localparam logic [4:0] K_UTFLEN = 5'd7;
  localparam logic [4:0] K_UTFBYTE = 5'd8;
  localparam logic [4:0] K_ICOUNT = 5'd12;
  localparam logic [4:0] K_IFACE = 5'd13;
  localparam logic [4:0] K_FCOUNT = 5'd14;
  localparam logic [4:0] K_MACOUNT = 5'd18;
  localparam logic [4:0] K_MCOUNT = 5'd19;
  localparam logic [4:0] K_ALEN = 5'd21;
  localparam logic [4:0] K_ABYTE = 5'd22;
  localparam logic [4:0] K_CACOUNT = 5'd23;
  localparam logic [4:0] K_END = 5'd24;
  localparam logic [4:0] K_ERROR = 5'd25;

  localparam logic [7:0] TAG_UTF8 = 8'd1;
  localparam logic [7:0] TAG_LONG = 8'd5;
  localparam logic [7:0] TAG_DOUBLE = 8'd6;
  localparam logic [7:0] TAG_MHANDLE = 8'd15;
  localparam logic [7:0] TAG_DYNAMIC = 8'd17;
  localparam logic [7:0] TAG_PACKAGE = 8'd20;
  localparam logic [15:0] MAJOR_OLDEST = 16'd45;
  localparam logic [15:0] MAJOR_SE7 = 16'd51;
  localparam logic [15:0] MAJOR_SE11 = 16'd55;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [4:0] kind;
    logic [31:0] value;
    logic [15:0] slot;
    logic [2:0] se;
    logic eof;
  } token_t;
endpackage

/* rtl/core/jcf_front.sv */
// Front end: accepts stream bytes and builds tokens with the parse state machine.
`timescale 1ns / 1ps
module jcf_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] data_byte,
  input  logic start_of_file,
  output logic tok_valid,
  output jcf_pkg::token_t tok,
  input  logic tok_space
);
  jcf_pkg::phase_t phase, phase_next;
  logic [1:0] bif, bif_next;
  logic [31:0] acc, acc_next;
  logic [7:0] tag, tag_next;
  logic [1:0] sub, sub_next;
  logic [15:0] pleft, pleft_next, ppos, ppos_next, lleft, lleft_next, aleft, aleft_next;
  logic [31:0] bleft, bleft_next;
  logic meth, meth_next;

  logic fire;
  assign in_ready = tok_space;
  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jcf_pkg::PH_IDLE; bif <= '0; acc <= '0; tag <= '0; sub <= '0;
      pleft <= '0; ppos <= '0; lleft <= '0; aleft <= '0; bleft <= '0; meth <= 1'b0;
    end else if (fire) begin
      phase <= phase_next; bif <= bif_next; acc <= acc_next; tag <= tag_next;
      sub <= sub_next; pleft <= pleft_next; ppos <= ppos_next; lleft <= lleft_next;
      aleft <= aleft_next; bleft <= bleft_next; meth <= meth_next;
    end
  end

  always_comb begin
    jcf_pkg::phase_t ph;
    logic [1:0] b0;
    logic [31:0] a0, sh, v;
    logic [1:0] need;
    logic done, known, two;
    logic [15:0] ll, al, slots;
    logic [31:0] bl;
    ph = phase; b0 = bif; a0 = acc;
    tag_next = tag; sub_next = sub; pleft_next = pleft; ppos_next = ppos;
    lleft_next = lleft; aleft_next = aleft; bleft_next = bleft; meth_next = meth;
    if (start_of_file) begin
      ph = jcf_pkg::PH_MAGIC; b0 = '0; a0 = '0; tag_next = '0; sub_next = '0;
      pleft_next = '0; ppos_next = '0; lleft_next = '0; aleft_next = '0;
      bleft_next = '0; meth_next = 1'b0;
    end
    phase_next = ph;
    tok_valid = 1'b0;
    tok = '0;
    need = 2'd1;
    case (ph)
      jcf_pkg::PH_MAGIC, jcf_pkg::PH_ALEN: need = 2'd3;
      jcf_pkg::PH_PBODY: begin
        if (tag == 8'd3 || tag == 8'd4 || tag == jcf_pkg::TAG_LONG ||
            tag == jcf_pkg::TAG_DOUBLE) need = 2'd3;
        else if (tag == jcf_pkg::TAG_MHANDLE && sub == 2'd0) need = 2'd0;
        else need = 2'd1;
      end
      default: need = 2'd1;
    endcase
    sh = {a0[23:0], data_byte};
    acc_next = sh;
    done = (b0 >= need);
    bif_next = done ? 2'd0 : b0 + 2'd1;
    v = (need == 2'd3) ? sh : (need == 2'd0 ? {24'd0, sh[7:0]} : {16'd0, sh[15:0]});
    two = (tag == jcf_pkg::TAG_LONG || tag == jcf_pkg::TAG_DOUBLE);
    slots = two ? 16'd2 : 16'd1;
    ll = lleft; al = aleft; bl = bleft_next;
    known = (data_byte == 8'd1) || (data_byte >= 8'd3 && data_byte <= 8'd12) ||
            (data_byte >= jcf_pkg::TAG_MHANDLE && data_byte <= jcf_pkg::TAG_PACKAGE);
    tok.kind = ph;
    tok.value = v;
    case (ph)
      jcf_pkg::PH_IDLE, jcf_pkg::PH_ERROR: begin
        acc_next = acc; bif_next = bif;
      end
      jcf_pkg::PH_DONE: begin
        acc_next = a0; bif_next = b0;
        tok_valid = 1'b1; tok.kind = jcf_pkg::K_END; tok.value = {24'd0, data_byte};
        tok.eof = 1'b1;
      end
      jcf_pkg::PH_MAGIC, jcf_pkg::PH_MINOR: begin
        tok_valid = done;
        if (done) phase_next = (ph == jcf_pkg::PH_MAGIC) ? jcf_pkg::PH_MINOR : jcf_pkg::PH_MAJOR;
        tok.kind = (ph == jcf_pkg::PH_MAGIC) ? jcf_pkg::K_MAGIC : jcf_pkg::K_MINOR;
      end
      jcf_pkg::PH_MAJOR: begin
        tok_valid = done; tok.kind = jcf_pkg::K_MAJOR;
        if (v[15:0] < jcf_pkg::MAJOR_OLDEST) tok.se = 3'd0;
        else if (v[15:0] >= jcf_pkg::MAJOR_SE7 && v[15:0] <= jcf_pkg::MAJOR_SE11)
          tok.se = 3'(v[15:0] - jcf_pkg::MAJOR_SE7 + 16'd2);
        else tok.se = 3'd1;
        if (done) phase_next = jcf_pkg::PH_PCOUNT;
      end
      jcf_pkg::PH_PCOUNT: begin
        tok_valid = done; tok.kind = jcf_pkg::K_PCOUNT;
        if (done) begin
          pleft_next = (v[15:0] != 16'd0) ? v[15:0] - 16'd1 : 16'd0;
          ppos_next = 16'd1;
          phase_next = (v[15:0] > 16'd1) ? jcf_pkg::PH_PTAG : jcf_pkg::PH_CFLAGS;
        end
      end
      jcf_pkg::PH_PTAG: begin
        acc_next = a0; tok_valid = 1'b1; tok.slot = ppos; tok.value = {24'd0, data_byte};
        if (!known) begin
          phase_next = jcf_pkg::PH_ERROR; tok.kind = jcf_pkg::K_ERROR; tok.eof = 1'b1;
          bif_next = b0;
        end else begin
          tok.kind = jcf_pkg::K_PTAG; tag_next = data_byte; sub_next = 2'd0; bif_next = 2'd0;
          phase_next = (data_byte == jcf_pkg::TAG_UTF8) ? jcf_pkg::PH_UTFLEN : jcf_pkg::PH_PBODY;
        end
      end
      jcf_pkg::PH_PBODY, jcf_pkg::PH_UTFLEN, jcf_pkg::PH_UTFBYTES: begin
        logic edone;
        edone = 1'b0;
        tok.slot = ppos;
        if (ph == jcf_pkg::PH_PBODY) begin
          tok_valid = done; tok.kind = (need == 2'd3) ? jcf_pkg::K_PU32 : jcf_pkg::K_PU16;
          if (done) begin
            if ({1'b0, sub} + 3'd1 >= ((tag == 8'd3 || tag == 8'd4 || tag == 8'd7 ||
                tag == 8'd8 || tag == 8'd16 || tag == 8'd19 || tag == jcf_pkg::TAG_PACKAGE)
                ? 3'd1 : 3'd2)) edone = 1'b1;
            else sub_next = sub + 2'd1;
          end
        end else if (ph == jcf_pkg::PH_UTFLEN) begin
          tok_valid = done; tok.kind = jcf_pkg::K_UTFLEN;
          if (done) begin
            bleft_next = v;
            if (v == 32'd0) edone = 1'b1; else phase_next = jcf_pkg::PH_UTFBYTES;
          end
        end else begin
          acc_next = a0; bif_next = b0;
          tok_valid = 1'b1; tok.kind = jcf_pkg::K_UTFBYTE; tok.value = {24'd0, data_byte};
          bl = (bleft != 32'd0) ? bleft - 32'd1 : 32'd0;
          bleft_next = bl;
          edone = (bl == 32'd0);
        end
        if (edone) begin
          ppos_next = ppos + slots;
          pleft_next = (pleft > slots) ? pleft - slots : 16'd0;
          phase_next = (pleft > slots) ? jcf_pkg::PH_PTAG : jcf_pkg::PH_CFLAGS;
        end
      end
      jcf_pkg::PH_CFLAGS, jcf_pkg::PH_THIS, jcf_pkg::PH_SUPER, jcf_pkg::PH_MFLAGS,
      jcf_pkg::PH_MNAME, jcf_pkg::PH_MDESC, jcf_pkg::PH_ANAME: begin
        tok_valid = done;
        if (done) phase_next = jcf_pkg::phase_t'(ph + 5'd1);
      end
      jcf_pkg::PH_ICOUNT, jcf_pkg::PH_FCOUNT, jcf_pkg::PH_MCOUNT: begin
        tok_valid = done;
        if (done) begin
          lleft_next = v[15:0];
          if (ph == jcf_pkg::PH_ICOUNT)
            phase_next = (v[15:0] != 0) ? jcf_pkg::PH_IFACE : jcf_pkg::PH_FCOUNT;
          else if (ph == jcf_pkg::PH_FCOUNT) begin
            meth_next = 1'b0;
            phase_next = (v[15:0] != 0) ? jcf_pkg::PH_MFLAGS : jcf_pkg::PH_MCOUNT;
          end else begin
            meth_next = 1'b1;
            phase_next = (v[15:0] != 0) ? jcf_pkg::PH_MFLAGS : jcf_pkg::PH_CACOUNT;
          end
        end
      end
      jcf_pkg::PH_IFACE: begin
        tok_valid = done;
        if (done) begin
          ll = (lleft != 0) ? lleft - 16'd1 : 16'd0;
          lleft_next = ll;
          if (ll == 0) phase_next = jcf_pkg::PH_FCOUNT;
        end
      end
      jcf_pkg::PH_MACOUNT, jcf_pkg::PH_ALEN, jcf_pkg::PH_ABYTES: begin
        logic adone, mdone;
        adone = 1'b0; mdone = 1'b0;
        if (ph == jcf_pkg::PH_MACOUNT) begin
          tok_valid = done;
          if (done) begin
            aleft_next = v[15:0];
            if (v[15:0] == 0) mdone = 1'b1; else phase_next = jcf_pkg::PH_ANAME;
          end
        end else if (ph == jcf_pkg::PH_ALEN) begin
          tok_valid = done;
          if (done) begin
            bleft_next = v;
            if (v == 32'd0) adone = 1'b1; else phase_next = jcf_pkg::PH_ABYTES;
          end
        end else begin
          acc_next = a0; bif_next = b0;
          tok_valid = 1'b1; tok.value = {24'd0, data_byte};
          bl = (bleft != 32'd0) ? bleft - 32'd1 : 32'd0;
          bleft_next = bl;
          adone = (bl == 32'd0);
        end
        if (adone) begin
          al = (aleft != 0) ? aleft - 16'd1 : 16'd0;
          aleft_next = al;
          if (al != 0) phase_next = jcf_pkg::PH_ANAME;
          else if (meth && lleft == 0) begin
            phase_next = jcf_pkg::PH_DONE; tok.eof = 1'b1;
          end else mdone = 1'b1;
        end
        if (mdone) begin
          ll = (lleft != 0) ? lleft - 16'd1 : 16'd0;
          lleft_next = ll;
          if (ll != 0) phase_next = jcf_pkg::PH_MFLAGS;
          else phase_next = meth ? jcf_pkg::PH_CACOUNT : jcf_pkg::PH_MCOUNT;
        end
      end
      jcf_pkg::PH_CACOUNT: begin
        tok_valid = done;
        if (done) begin
          aleft_next = v[15:0]; lleft_next = '0; meth_next = 1'b1;
          if (v[15:0] == 0) begin
            phase_next = jcf_pkg::PH_DONE; tok.eof = 1'b1;
          end else phase_next = jcf_pkg::PH_ANAME;
        end
      end
      default: begin
        acc_next = acc; bif_next = bif;
      end
    endcase
    if (!in_valid) tok_valid = 1'b0;
  end
endmodule

/* rtl/core/jcf_queue.sv */
// Token queue between the parse front end and the output port.
`timescale 1ns / 1ps
module jcf_queue #(
  parameter int DEPTH = jcf_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  jcf_pkg::token_t push_tok,
  output logic space,
  output logic out_valid,
  output jcf_pkg::token_t out_tok,
  input  logic out_ready
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  jcf_pkg::token_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic pop;
  assign space = (cnt != (AW+1)'(DEPTH));
  assign out_valid = (cnt != '0);
  assign pop = out_valid && out_ready;
  assign out_tok = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_tok;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

/* rtl/core/java_class_file_token_parser.sv */
// Top level of the class file token parser.
// Channel  | Handshake              | Payload
// input    | in_valid / in_ready    | data_byte, start_of_file
// output   | out_valid / out_ready  | token_kind, token_value, pool_slot, java_se_class,
//          |                        | end_of_file
// One byte is taken every cycle while the token queue has space; the parse state updates on each byte.
// A token is written into the token queue when its byte is taken; the output is read from the queue.
// Reset leaves the parser idle until a byte flagged as start of file arrives.
// Input stalls only when the token queue is full.
`timescale 1ns / 1ps
module java_class_file_token_parser #(
  parameter int QUEUE_DEPTH = jcf_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] data_byte,
  input  logic start_of_file,
  output logic out_valid,
  input  logic out_ready,
  output logic [4:0] token_kind,
  output logic [31:0] token_value,
  output logic [15:0] pool_slot,
  output logic [2:0] java_se_class,
  output logic end_of_file
);
  logic tv, space;
  jcf_pkg::token_t tok, otok;
  jcf_front u_front (.clk, .rst, .in_valid, .in_ready, .data_byte, .start_of_file,
    .tok_valid(tv), .tok(tok), .tok_space(space));
  jcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (.clk, .rst, .push(tv && in_ready),
    .push_tok(tok), .space(space), .out_valid, .out_tok(otok), .out_ready);
  assign token_kind = otok.kind;
  assign token_value = otok.value;
  assign pool_slot = otok.slot;
  assign java_se_class = otok.se;
  assign end_of_file = otok.eof;
endmodule

/* rtl/core/jcf_checker.sv */
// Port checker for the class file token parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jcf_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [4:0] token_kind,
  input logic [2:0] java_se_class,
  input logic end_of_file
);
  logic is_final;
  assign is_final = (token_kind == jcf_pkg::K_ERROR) || (token_kind == jcf_pkg::K_END);

  `CHK_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(token_kind))
  `CHK_IMPLIES(kind_range, clk, rst, out_valid, token_kind <= jcf_pkg::K_ERROR)
  `CHK_IMPLIES(err_eof, clk, rst, out_valid && is_final, end_of_file)
  `CHK_IMPLIES(se_major, clk, rst, out_valid && token_kind != jcf_pkg::K_MAJOR, java_se_class == 3'd0)
endmodule

bind java_class_file_token_parser jcf_checker u_chk (.clk, .rst, .out_valid, .out_ready,
  .token_kind, .java_se_class, .end_of_file);

/* test/java_class_file_token_parser_tb.sv */
// Testbench for the class file token parser: generated class files, a predictor, a checker.
`timescale 1ns / 1ps
module java_class_file_token_parser_tb;

  typedef struct packed {
    logic [7:0] data;
    logic sof;
  } byte_req_t;

  localparam int IDLE_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'd0;
  logic start_of_file = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] token_kind;
  logic [31:0] token_value;
  logic [15:0] pool_slot;
  logic [2:0] java_se_class;
  logic end_of_file;

  java_class_file_token_parser u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .start_of_file(start_of_file), .out_valid(out_valid),
    .out_ready(out_ready), .token_kind(token_kind), .token_value(token_value),
    .pool_slot(pool_slot), .java_se_class(java_se_class), .end_of_file(end_of_file)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_req_t pending_bytes[$];
  logic [7:0] file_bytes[$];
  jcf_pkg::token_t expected_tokens[$];
  int errors = 0;
  int bytes_taken = 0;
  int idle_cycles = 0;
  int cycle_count = 0;
  bit byte_taken = 0;
  bit token_taken = 0;

  // Parser state mirrored by the predictor.
  jcf_pkg::phase_t phase = jcf_pkg::PH_IDLE;
  logic [1:0] byte_idx = '0;
  logic [31:0] acc = '0;
  logic [7:0] tag = '0;
  logic [1:0] sub_idx = '0;
  logic [15:0] slots_left = '0;
  logic [15:0] slot_pos = '0;
  logic [15:0] items_left = '0;
  logic [15:0] attrs_left = '0;
  logic [31:0] payload_left = '0;
  bit in_methods = 0;

  function automatic bit tag_known(input logic [7:0] t);
    return t == jcf_pkg::TAG_UTF8 || (t >= 8'd3 && t <= 8'd12) ||
           (t >= jcf_pkg::TAG_MHANDLE && t <= jcf_pkg::TAG_PACKAGE);
  endfunction

  function automatic int body_count(input logic [7:0] t);
    case (t)
      8'd3, 8'd4, 8'd7, 8'd8, 8'd16, 8'd19, jcf_pkg::TAG_PACKAGE: return 1;
      default: return 2;
    endcase
  endfunction

  function automatic int body_width(input logic [7:0] t, input int sub);
    if (t == 8'd3 || t == 8'd4 || t == jcf_pkg::TAG_LONG || t == jcf_pkg::TAG_DOUBLE) return 4;
    if (t == jcf_pkg::TAG_MHANDLE && sub == 0) return 1;
    return 2;
  endfunction

  function automatic bit shift_in(input logic [7:0] b, input int need);
    acc = {acc[23:0], b};
    if (int'(byte_idx) + 1 >= need) begin
      byte_idx = '0;
      return 1;
    end
    byte_idx = byte_idx + 2'd1;
    return 0;
  endfunction

  function automatic logic [31:0] field_of(input int need);
    if (need == 4) return acc;
    if (need == 2) return {16'd0, acc[15:0]};
    return {24'd0, acc[7:0]};
  endfunction

  function automatic jcf_pkg::token_t mk(input logic [4:0] k, input logic [31:0] v,
                                         input logic [15:0] s, input logic [2:0] se,
                                         input logic e);
    return jcf_pkg::token_t'{kind: k, value: v, slot: s, se: se, eof: e};
  endfunction

  function automatic void entry_done();
    logic [15:0] used;
    used = (tag == jcf_pkg::TAG_LONG || tag == jcf_pkg::TAG_DOUBLE) ? 16'd2 : 16'd1;
    slot_pos = slot_pos + used;
    slots_left = slots_left > used ? slots_left - used : 16'd0;
    phase = slots_left != 0 ? jcf_pkg::PH_PTAG : jcf_pkg::PH_CFLAGS;
  endfunction

  function automatic void member_done();
    if (items_left != 0) items_left = items_left - 1'b1;
    if (items_left != 0) phase = jcf_pkg::PH_MFLAGS;
    else phase = in_methods ? jcf_pkg::PH_CACOUNT : jcf_pkg::PH_MCOUNT;
  endfunction

  function automatic bit attr_done();
    if (attrs_left != 0) attrs_left = attrs_left - 1'b1;
    if (attrs_left != 0) begin
      phase = jcf_pkg::PH_ANAME;
      return 0;
    end
    if (in_methods && items_left == 0) begin
      phase = jcf_pkg::PH_DONE;
      return 1;
    end
    member_done();
    return 0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic sof, output bit got,
                            output jcf_pkg::token_t t);
    logic [31:0] v;
    logic [2:0] se;
    int need;
    bit e;
    got = 0;
    t = '0;
    if (sof) begin
      byte_idx = '0; acc = '0; tag = '0; sub_idx = '0; slots_left = '0; slot_pos = '0;
      items_left = '0; attrs_left = '0; payload_left = '0; in_methods = 0;
      phase = jcf_pkg::PH_MAGIC;
    end
    case (phase)
      jcf_pkg::PH_DONE: begin
        t = mk(jcf_pkg::K_END, {24'd0, b}, 16'd0, 3'd0, 1'b1); got = 1;
      end
      jcf_pkg::PH_MAGIC: if (shift_in(b, 4)) begin
        phase = jcf_pkg::PH_MINOR; t = mk(jcf_pkg::K_MAGIC, acc, 16'd0, 3'd0, 1'b0); got = 1;
      end
      jcf_pkg::PH_MINOR: if (shift_in(b, 2)) begin
        phase = jcf_pkg::PH_MAJOR;
        t = mk(jcf_pkg::K_MINOR, field_of(2), 16'd0, 3'd0, 1'b0); got = 1;
      end
      jcf_pkg::PH_MAJOR: if (shift_in(b, 2)) begin
        v = field_of(2);
        if (v < jcf_pkg::MAJOR_OLDEST) se = 3'd0;
        else if (v >= jcf_pkg::MAJOR_SE7 && v <= jcf_pkg::MAJOR_SE11)
          se = 3'(v - jcf_pkg::MAJOR_SE7 + 2);
        else se = 3'd1;
        phase = jcf_pkg::PH_PCOUNT; t = mk(jcf_pkg::K_MAJOR, v, 16'd0, se, 1'b0); got = 1;
      end
      jcf_pkg::PH_PCOUNT: if (shift_in(b, 2)) begin
        v = field_of(2);
        slots_left = v != 0 ? v[15:0] - 16'd1 : 16'd0;
        slot_pos = 16'd1;
        phase = slots_left != 0 ? jcf_pkg::PH_PTAG : jcf_pkg::PH_CFLAGS;
        t = mk(jcf_pkg::K_PCOUNT, v, 16'd0, 3'd0, 1'b0); got = 1;
      end
      jcf_pkg::PH_PTAG: begin
        got = 1;
        if (!tag_known(b)) begin
          phase = jcf_pkg::PH_ERROR;
          t = mk(jcf_pkg::K_ERROR, {24'd0, b}, slot_pos, 3'd0, 1'b1);
        end else begin
          tag = b; sub_idx = '0; byte_idx = '0;
          phase = b == jcf_pkg::TAG_UTF8 ? jcf_pkg::PH_UTFLEN : jcf_pkg::PH_PBODY;
          t = mk(jcf_pkg::K_PTAG, {24'd0, b}, slot_pos, 3'd0, 1'b0);
        end
      end
      jcf_pkg::PH_PBODY: begin
        need = body_width(tag, sub_idx);
        if (shift_in(b, need)) begin
          t = mk(need == 4 ? jcf_pkg::K_PU32 : jcf_pkg::K_PU16, field_of(need), slot_pos,
                 3'd0, 1'b0);
          got = 1;
          if (int'(sub_idx) + 1 >= body_count(tag)) entry_done();
          else sub_idx = sub_idx + 2'd1;
        end
      end
      jcf_pkg::PH_UTFLEN: if (shift_in(b, 2)) begin
        v = field_of(2);
        t = mk(jcf_pkg::K_UTFLEN, v, slot_pos, 3'd0, 1'b0); got = 1;
        payload_left = v;
        if (v == 0) entry_done();
        else phase = jcf_pkg::PH_UTFBYTES;
      end
      jcf_pkg::PH_UTFBYTES: begin
        t = mk(jcf_pkg::K_UTFBYTE, {24'd0, b}, slot_pos, 3'd0, 1'b0); got = 1;
        if (payload_left != 0) payload_left = payload_left - 1;
        if (payload_left == 0) entry_done();
      end
      jcf_pkg::PH_CFLAGS, jcf_pkg::PH_THIS, jcf_pkg::PH_SUPER, jcf_pkg::PH_MFLAGS,
      jcf_pkg::PH_MNAME, jcf_pkg::PH_MDESC, jcf_pkg::PH_ANAME:
        if (shift_in(b, 2)) begin
          t = mk(phase, field_of(2), 16'd0, 3'd0, 1'b0); got = 1;
          phase = jcf_pkg::phase_t'(phase + 5'd1);
        end
      jcf_pkg::PH_ICOUNT: if (shift_in(b, 2)) begin
        v = field_of(2);
        items_left = v[15:0];
        phase = v != 0 ? jcf_pkg::PH_IFACE : jcf_pkg::PH_FCOUNT;
        t = mk(jcf_pkg::K_ICOUNT, v, 16'd0, 3'd0, 1'b0); got = 1;
      end
      jcf_pkg::PH_IFACE: if (shift_in(b, 2)) begin
        t = mk(jcf_pkg::K_IFACE, field_of(2), 16'd0, 3'd0, 1'b0); got = 1;
        if (items_left != 0) items_left = items_left - 1'b1;
        if (items_left == 0) phase = jcf_pkg::PH_FCOUNT;
      end
      jcf_pkg::PH_FCOUNT: if (shift_in(b, 2)) begin
        v = field_of(2);
        items_left = v[15:0]; in_methods = 0;
        phase = v != 0 ? jcf_pkg::PH_MFLAGS : jcf_pkg::PH_MCOUNT;
        t = mk(jcf_pkg::K_FCOUNT, v, 16'd0, 3'd0, 1'b0); got = 1;
      end
      jcf_pkg::PH_MACOUNT: if (shift_in(b, 2)) begin
        v = field_of(2);
        attrs_left = v[15:0];
        t = mk(jcf_pkg::K_MACOUNT, v, 16'd0, 3'd0, 1'b0); got = 1;
        if (v == 0) member_done();
        else phase = jcf_pkg::PH_ANAME;
      end
      jcf_pkg::PH_MCOUNT: if (shift_in(b, 2)) begin
        v = field_of(2);
        items_left = v[15:0]; in_methods = 1;
        phase = v != 0 ? jcf_pkg::PH_MFLAGS : jcf_pkg::PH_CACOUNT;
        t = mk(jcf_pkg::K_MCOUNT, v, 16'd0, 3'd0, 1'b0); got = 1;
      end
      jcf_pkg::PH_ALEN: if (shift_in(b, 4)) begin
        v = acc;
        payload_left = v;
        e = 0;
        if (v == 0) e = attr_done();
        else phase = jcf_pkg::PH_ABYTES;
        t = mk(jcf_pkg::K_ALEN, v, 16'd0, 3'd0, e); got = 1;
      end
      jcf_pkg::PH_ABYTES: begin
        if (payload_left != 0) payload_left = payload_left - 1;
        e = 0;
        if (payload_left == 0) e = attr_done();
        t = mk(jcf_pkg::K_ABYTE, {24'd0, b}, 16'd0, 3'd0, e); got = 1;
      end
      jcf_pkg::PH_CACOUNT: if (shift_in(b, 2)) begin
        v = field_of(2);
        attrs_left = v[15:0]; items_left = '0; in_methods = 1;
        e = v == 0;
        phase = e ? jcf_pkg::PH_DONE : jcf_pkg::PH_ANAME;
        t = mk(jcf_pkg::K_CACOUNT, v, 16'd0, 3'd0, e); got = 1;
      end
      default: ;
    endcase
  endtask

  // Class file generator.
  task automatic put8(input logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endtask

  task automatic put_attrs(input int n);
    int len;
    for (int i = 0; i < n; i++) begin
      put16(16'($urandom));
      len = $urandom_range(0, 3);
      put32(len);
      for (int j = 0; j < len; j++) put8(8'($urandom));
    end
  endtask

  task automatic put_members(input int n, input bit lean);
    for (int i = 0; i < n; i++) begin
      put16(16'($urandom)); put16(16'($urandom)); put16(16'($urandom));
      put16(16'(lean ? 0 : $urandom_range(0, 2)));
      put_attrs(int'(file_bytes[file_bytes.size() - 1]));
    end
  endtask

  task automatic add_class(input logic [15:0] major, input bit lean);
    int n, left, len, cnt;
    logic [7:0] t;
    bit broken;
    broken = 0;
    file_bytes.delete();
    case ($urandom_range(0, 3))
      0: put32(32'hCAFEBABE);
      1: put32(32'hFFFFFFFF);
      2: put32(32'h0);
      default: put32($urandom);
    endcase
    put16(16'($urandom));
    put16(major);
    n = lean ? $urandom_range(0, 1) : $urandom_range(0, 7);
    put16(16'(n));
    left = n != 0 ? n - 1 : 0;
    while (left > 0 && !broken) begin
      if (!lean && $urandom_range(0, 19) == 0) begin
        do t = 8'($urandom); while (tag_known(t));
        put8(t);
        broken = 1;
      end else begin
        do t = 8'($urandom_range(1, 20)); while (!tag_known(t));
        put8(t);
        if (t == jcf_pkg::TAG_UTF8) begin
          len = $urandom_range(0, 3);
          put16(16'(len));
          for (int j = 0; j < len; j++) put8(8'($urandom));
        end else begin
          for (int s = 0; s < body_count(t); s++)
            for (int j = 0; j < body_width(t, s); j++) put8(8'($urandom));
        end
        left -= (t == jcf_pkg::TAG_LONG || t == jcf_pkg::TAG_DOUBLE) ? 2 : 1;
      end
    end
    if (!broken) begin
      put16(16'($urandom)); put16(16'($urandom)); put16(16'($urandom));
      cnt = lean ? 0 : $urandom_range(0, 2);
      put16(16'(cnt));
      for (int i = 0; i < cnt; i++) put16(16'($urandom));
      cnt = lean ? 0 : $urandom_range(0, 2);
      put16(16'(cnt));
      put_members(cnt, lean);
      cnt = lean ? 0 : $urandom_range(0, 2);
      put16(16'(cnt));
      put_members(cnt, lean);
      cnt = lean ? 0 : $urandom_range(0, 2);
      put16(16'(cnt));
      put_attrs(cnt);
    end
    for (int i = $urandom_range(0, 2); i > 0; i--) put8(8'($urandom));
    if (!lean && $urandom_range(0, 7) == 0)
      while (file_bytes.size() > 1 && $urandom_range(0, 15) != 0) void'(file_bytes.pop_back());
    foreach (file_bytes[i]) pending_bytes.push_back(byte_req_t'{data: file_bytes[i], sof: i == 0});
  endtask

  initial begin
    logic [15:0] majors[8] = '{16'd0, 16'd44, 16'd45, 16'd51, 16'd53, 16'd55, 16'd56, 16'hFFFF};
    // Stray bytes before the first start are ignored.
    pending_bytes.push_back(byte_req_t'{data: 8'hFF, sof: 1'b0});
    pending_bytes.push_back(byte_req_t'{data: 8'h00, sof: 1'b0});
    add_class(16'd0, 1);
    add_class(16'hFFFF, 1);
    add_class(16'd51, 1);
    while (pending_bytes.size() < 330) add_class(majors[$urandom_range(0, 7)], 0);
    for (int i = 0; i < 15; i++)
      pending_bytes.push_back(byte_req_t'{data: 8'($urandom), sof: $urandom_range(0, 5) == 0});
    add_class(16'd52, 0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_bytes.size() == 0 && !in_valid);
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) $display("** java_class_file_token_parser: PASSED **");
    else $display("** java_class_file_token_parser: FAILED **");
    $finish;
  end

  // Accept bytes and tokens, predict and check.
  always @(posedge clk) begin
    bit got;
    jcf_pkg::token_t t;
    jcf_pkg::token_t exp_tok;
    cycle_count++;
    if (!rst) begin
      if (in_valid && in_ready) begin
        parse_byte(data_byte, start_of_file, got, t);
        if (got) expected_tokens.push_back(t);
        bytes_taken++;
        byte_taken = 1;
      end
      if (out_valid && out_ready) begin
        token_taken = 1;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token kind %0d value %h", $time, token_kind, token_value);
          errors++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (token_kind !== exp_tok.kind) begin
            $display("%0t: token_kind expected %0d actual %0d", $time, exp_tok.kind, token_kind);
            errors++;
          end
          if (token_value !== exp_tok.value) begin
            $display("%0t: token_value expected %h actual %h", $time, exp_tok.value, token_value);
            errors++;
          end
          if (pool_slot !== exp_tok.slot) begin
            $display("%0t: pool_slot expected %0d actual %0d", $time, exp_tok.slot, pool_slot);
            errors++;
          end
          if (java_se_class !== exp_tok.se) begin
            $display("%0t: java_se_class expected %0d actual %0d", $time, exp_tok.se,
                     java_se_class);
            errors++;
          end
          if (end_of_file !== exp_tok.eof) begin
            $display("%0t: end_of_file expected %0d actual %0d", $time, exp_tok.eof, end_of_file);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout", $time);
        $display("** java_class_file_token_parser: FAILED **");
        $finish;
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    int gap;
    if (!rst) begin
      if (in_valid && !byte_taken) begin
      end else if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        data_byte <= pending_bytes[0].data;
        start_of_file <= pending_bytes[0].sof;
        void'(pending_bytes.pop_front());
        in_valid <= 1'b1;
        gap = cycle_count[8:7] == 2'd0 ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
      byte_taken = 0;
    end
  end

  // Token receiver with one long hold-off.
  always @(negedge clk) begin
    int stall;
    int hold;
    bit held;
    if (!rst) begin
      if (token_taken) stall = cycle_count[9:8] == 2'd1 ? 0 : $urandom_range(0, 9);
      token_taken = 0;
      if (!held && bytes_taken >= 150) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end
endmodule
